### rtl/core/vbs_pkg.sv
// ----------------------------------------------------------------------------
// vbs_pkg: shared types and constants for the volatility breakout signal
// Beat formats, field widths, register codes and reset values.
// ----------------------------------------------------------------------------
package vbs_pkg;

   localparam int PRICE_W    = 32;
   localparam int TIME_W     = 40;
   localparam int MOVE_W     = 24;
   localparam int LAT_W      = 24;
   localparam int VM_W       = 16;
   localparam int BPS_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int SHORT_WINDOW_DEF = 16;
   localparam int LONG_WINDOW_DEF  = 256;

   // 10000 bps * 256 (Q8) = 625 << 12
   localparam int BPS_SCALE     = 625;
   localparam int BPS_SHIFT     = 12;
   localparam int SCALED_W      = PRICE_W + 10;
   localparam int DIV_NUM_W     = SCALED_W + BPS_SHIFT;
   localparam int HOLD_LIMIT_MS = 4000;
   localparam int EDGE_W        = BPS_W + 4;

   localparam int MUL_A_W   = 64;
   localparam int MUL_DIG_W = 16;
   localparam int MUL_B_W   = 2 * MUL_DIG_W;

   localparam logic [VM_W-1:0]  VOL_MULT_RST = 16'd512;
   localparam logic [BPS_W-1:0] MIN_EDGE_RST = 24'd1280;
   localparam logic [BPS_W-1:0] TARGET_RST   = 24'd2560;
   localparam logic [BPS_W-1:0] STOP_RST     = 24'd1280;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOL_MULT = 2'd0,
      CSR_MIN_EDGE = 2'd1,
      CSR_TARGET   = 2'd2,
      CSR_STOP     = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [PRICE_W-1:0] tick_price;
      logic [TIME_W-1:0]  tick_time_ms;
      logic [LAT_W-1:0]   latency_ms;
   } req_type;

   typedef struct packed {
      logic               entry_flag;
      logic               exit_flag;
      logic [PRICE_W-1:0] opened_at_price;
      logic [PRICE_W-1:0] closed_at_price;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MUL_A_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [PRICE_W-1:0]   den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [MOVE_W-1:0] quot;
   } div_rsp_type;

endpackage

### rtl/core/vbs_mul.sv
// ----------------------------------------------------------------------------
// vbs_mul: shared multiplier
// 64 x 32 product, one 16-bit digit of b per cycle into an accumulator.
// ----------------------------------------------------------------------------
module vbs_mul
   import vbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic [MUL_A_W-1:0]           a_ff, a_in;
   logic [MUL_B_W-1:0]           b_ff, b_in;
   logic [MUL_A_W-1:0]           acc_ff, acc_in;
   logic                         busy_ff, busy_in;
   logic                         step_ff, step_in;
   logic                         done_ff, done_in;
   logic [MUL_DIG_W-1:0]         dig;
   logic [MUL_A_W+MUL_DIG_W-1:0] part;
   logic [MUL_A_W-1:0]           addend;

   assign dig    = step_ff ? b_ff[MUL_B_W-1:MUL_DIG_W] : b_ff[MUL_DIG_W-1:0];
   assign part   = a_ff * dig;
   assign addend = step_ff ? {part[MUL_A_W-MUL_DIG_W-1:0], {MUL_DIG_W{1'b0}}}
                           : part[MUL_A_W-1:0];

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         a_in    = mul_req.a;
         b_in    = mul_req.b;
         acc_in  = '0;
         busy_in = 1'b1;
         step_in = 1'b0;
      end else if (busy_ff) begin
         acc_in  = acc_ff + addend;
         step_in = !step_ff;
         if (step_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

### rtl/core/vbs_div.sv
// ----------------------------------------------------------------------------
// vbs_div: serial divider for the move in basis points
// Restoring division, one quotient bit a cycle, saturates at 24 bits.
// ----------------------------------------------------------------------------
module vbs_div
   import vbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int HI_W  = DIV_NUM_W - MOVE_W;
   localparam int CNT_W = $clog2(MOVE_W);

   logic [PRICE_W-1:0] rem_ff, rem_in;
   logic [PRICE_W-1:0] den_ff, den_in;
   logic [MOVE_W-1:0]  low_ff, low_in;
   logic [MOVE_W-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [HI_W-1:0]    num_hi;
   logic               sat;
   logic [PRICE_W:0]   trial;
   logic [PRICE_W:0]   trial_sub;
   logic               ge;

   assign num_hi    = div_req.num[DIV_NUM_W-1:MOVE_W];
   assign sat       = PRICE_W'(num_hi) >= div_req.den;
   assign trial     = {rem_ff, low_ff[MOVE_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign ge        = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         den_in = div_req.den;
         rem_in = PRICE_W'(num_hi);
         low_in = div_req.num[MOVE_W-1:0];
         cnt_in = '0;
         if (sat) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? trial_sub[PRICE_W-1:0] : trial[PRICE_W-1:0];
         low_in  = {low_ff[MOVE_W-2:0], 1'b0};
         quot_in = {quot_ff[MOVE_W-2:0], ge};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MOVE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

### rtl/core/vbs_ring.sv
// ----------------------------------------------------------------------------
// vbs_ring: sliding window of moves
// Ring memory with running total; fill count stands in for cleared entries.
// ----------------------------------------------------------------------------
module vbs_ring
   import vbs_pkg::*;
#(
   parameter  int DEPTH  = SHORT_WINDOW_DEF,
   localparam int POS_W  = $clog2(DEPTH),
   localparam int FILL_W = $clog2(DEPTH + 1),
   localparam int TOT_W  = MOVE_W + $clog2(DEPTH)
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [MOVE_W-1:0] push_value,
   output logic [TOT_W-1:0]  total,
   output logic              full
);

   logic [MOVE_W-1:0] mem [DEPTH];
   logic [MOVE_W-1:0] rd_ff;
   logic [MOVE_W-1:0] old_value;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [TOT_W-1:0]  total_ff, total_in;

   assign full      = fill_ff == FILL_W'(DEPTH);
   assign old_value = full ? rd_ff : '0;

   always_comb begin
      pos_in   = pos_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      if (push) begin
         total_in = total_ff - TOT_W'(old_value) + TOT_W'(push_value);
         pos_in   = (pos_ff == POS_W'(DEPTH - 1)) ? '0 : pos_ff + POS_W'(1);
         if (!full) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fill_ff  <= '0;
         total_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[pos_ff] <= push_value;
      end
      rd_ff <= mem[pos_ff];
   end

   assign total = total_ff;

endmodule

### rtl/core/volatility_breakout_signal.sv
// ----------------------------------------------------------------------------
// volatility_breakout_signal: long-only volatility breakout detector
// Tick in, one entry/exit beat out, with sliding move windows.
// ----------------------------------------------------------------------------
// One tick is in flight at a time: req_stall stays high from the accepting
// edge until the result is loaded into the output register, which then waits
// for the consumer while the next tick is taken. A tick with no previous
// price goes straight to the decision; otherwise the move runs on the
// shared 64x16-per-cycle multiplier and then on the bit-serial divider
// (one quotient bit a cycle, with no iterations when the move saturates),
// and the decision adds up to four more products on the multiplier.
// A stalled result beat holds the next tick in its last state, ST_FINISH.
// No clearing pass follows reset; the windows track their fill counts.
// ----------------------------------------------------------------------------
module volatility_breakout_signal
   import vbs_pkg::*;
#(
   parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
   parameter int LONG_WINDOW  = LONG_WINDOW_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ST_W  = MOVE_W + $clog2(SHORT_WINDOW);
   localparam int LT_W  = MOVE_W + $clog2(LONG_WINDOW);
   localparam int ST5_W = ST_W + 3;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_MV_MUL  = 11'b000_0000_0010,
      ST_MV_DIV  = 11'b000_0000_0100,
      ST_DECIDE  = 11'b000_0000_1000,
      ST_EN_P1   = 11'b000_0001_0000,
      ST_EN_P2A  = 11'b000_0010_0000,
      ST_EN_P2B  = 11'b000_0100_0000,
      ST_EN_EDGE = 11'b000_1000_0000,
      ST_EX_PA   = 11'b001_0000_0000,
      ST_EX_PB   = 11'b010_0000_0000,
      ST_FINISH  = 11'b100_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [VM_W-1:0]    vol_mult_ff, vol_mult_in;
   logic [BPS_W-1:0]   min_edge_ff, min_edge_in;
   logic [BPS_W-1:0]   target_ff, target_in;
   logic [BPS_W-1:0]   stop_ff, stop_in;
   logic [PRICE_W-1:0] prev_ff, prev_in;
   logic               holding_ff, holding_in;
   logic [PRICE_W-1:0] open_price_ff, open_price_in;
   logic [TIME_W-1:0]  open_time_ff, open_time_in;
   logic [PRICE_W-1:0] close_ff, close_in;
   logic               ent_ff, ent_in;
   logic               ext_ff, ext_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [LAT_W-1:0]   lat_ff, lat_in;
   logic [MUL_A_W-1:0] p_ff, p_in;

   mul_req_type        mul_req;
   mul_rsp_type        mul_rsp;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               push;
   logic [ST_W-1:0]    short_total;
   logic [LT_W-1:0]    long_total;
   logic               short_full;
   logic               long_full;

   logic               accept;
   logic               load_ok;
   logic [PRICE_W-1:0] tick_diff;
   logic [PRICE_W-1:0] hold_diff;
   logic [TIME_W-1:0]  elapsed;
   logic               timeout;
   logic [EDGE_W-1:0]  edge_sum;
   logic [ST5_W-1:0]   short_x5;
   logic [BPS_W-1:0]   hold_thr;

   vbs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   vbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   vbs_ring #(.DEPTH(SHORT_WINDOW)) u_short (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (div_rsp.quot),
      .total      (short_total),
      .full       (short_full)
   );

   vbs_ring #(.DEPTH(LONG_WINDOW)) u_long (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (div_rsp.quot),
      .total      (long_total),
      .full       (long_full)
   );

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign accept  = req_valid && !req_stall;
   assign load_ok = !rsp_valid_ff || !rsp_stall;

   assign tick_diff = (req_data.tick_price >= prev_ff) ? req_data.tick_price - prev_ff
                                                       : prev_ff - req_data.tick_price;
   assign hold_diff = (price_ff >= open_price_ff) ? price_ff - open_price_ff
                                                  : open_price_ff - price_ff;
   assign hold_thr  = (price_ff > open_price_ff) ? target_ff : stop_ff;
   assign elapsed   = time_ff - open_time_ff;
   assign timeout   = (time_ff >= open_time_ff) && (elapsed > TIME_W'(HOLD_LIMIT_MS));
   assign edge_sum  = EDGE_W'({min_edge_ff, 2'b00}) + EDGE_W'(min_edge_ff)
                    + EDGE_W'({lat_ff, 2'b00});
   assign short_x5  = ST5_W'({short_total, 2'b00}) + ST5_W'(short_total);

   always_comb begin
      state_in      = state_ff;
      vol_mult_in   = vol_mult_ff;
      min_edge_in   = min_edge_ff;
      target_in     = target_ff;
      stop_in       = stop_ff;
      prev_in       = prev_ff;
      holding_in    = holding_ff;
      open_price_in = open_price_ff;
      open_time_in  = open_time_ff;
      close_in      = close_ff;
      ent_in        = ent_ff;
      ext_in        = ext_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      price_in      = price_ff;
      time_in       = time_ff;
      lat_in        = lat_ff;
      p_in          = p_ff;
      mul_req       = '0;
      div_req       = '0;
      push          = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_VOL_MULT: vol_mult_in = csr_wdata[VM_W-1:0];
            CSR_MIN_EDGE: min_edge_in = csr_wdata[BPS_W-1:0];
            CSR_TARGET:   target_in   = csr_wdata[BPS_W-1:0];
            CSR_STOP:     stop_in     = csr_wdata[BPS_W-1:0];
            default:      ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               price_in = req_data.tick_price;
               time_in  = req_data.tick_time_ms;
               lat_in   = req_data.latency_ms;
               ent_in   = 1'b0;
               ext_in   = 1'b0;
               if (prev_ff != '0) begin
                  mul_req.start = 1'b1;
                  mul_req.a     = MUL_A_W'(tick_diff);
                  mul_req.b     = MUL_B_W'(BPS_SCALE);
                  state_in      = ST_MV_MUL;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_MV_MUL: begin
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = {mul_rsp.product[SCALED_W-1:0], {BPS_SHIFT{1'b0}}};
               div_req.den   = prev_ff;
               state_in      = ST_MV_DIV;
            end
         end
         ST_MV_DIV: begin
            if (div_rsp.done) begin
               push     = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            prev_in = price_ff;
            if (!holding_ff) begin
               if (short_full && long_full && (long_total != '0)) begin
                  mul_req.start = 1'b1;
                  mul_req.a     = MUL_A_W'(short_total);
                  mul_req.b     = MUL_B_W'(LONG_WINDOW * 256);
                  state_in      = ST_EN_P1;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (open_price_ff == '0) begin
               ext_in   = (price_ff != '0) || timeout;
               state_in = ST_FINISH;
            end else if (timeout) begin
               ext_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (price_ff == open_price_ff) begin
               ext_in   = (target_ff == '0) || (stop_ff == '0);
               state_in = ST_FINISH;
            end else begin
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(hold_diff);
               mul_req.b     = MUL_B_W'(BPS_SCALE);
               state_in      = ST_EX_PA;
            end
         end
         ST_EN_P1: begin
            if (mul_rsp.done) begin
               p_in          = mul_rsp.product;
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(long_total);
               mul_req.b     = MUL_B_W'(SHORT_WINDOW);
               state_in      = ST_EN_P2A;
            end
         end
         ST_EN_P2A: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = mul_rsp.product;
               mul_req.b     = MUL_B_W'(vol_mult_ff);
               state_in      = ST_EN_P2B;
            end
         end
         ST_EN_P2B: begin
            if (mul_rsp.done) begin
               if (p_ff > mul_rsp.product) begin
                  mul_req.start = 1'b1;
                  mul_req.a     = MUL_A_W'(edge_sum);
                  mul_req.b     = MUL_B_W'(SHORT_WINDOW);
                  state_in      = ST_EN_EDGE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_EN_EDGE: begin
            if (mul_rsp.done) begin
               ent_in   = MUL_A_W'(short_x5) > mul_rsp.product;
               state_in = ST_FINISH;
            end
         end
         ST_EX_PA: begin
            if (mul_rsp.done) begin
               p_in = {mul_rsp.product[MUL_A_W-BPS_SHIFT-1:0], {BPS_SHIFT{1'b0}}};
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(open_price_ff);
               mul_req.b     = MUL_B_W'(hold_thr);
               state_in      = ST_EX_PB;
            end
         end
         ST_EX_PB: begin
            if (mul_rsp.done) begin
               ext_in   = p_ff >= mul_rsp.product;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_ok) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.entry_flag      = ent_ff;
               rsp_data_in.exit_flag       = ext_ff;
               rsp_data_in.opened_at_price = ent_ff ? price_ff : open_price_ff;
               rsp_data_in.closed_at_price = ext_ff ? price_ff : close_ff;
               if (ent_ff) begin
                  holding_in    = 1'b1;
                  open_price_in = price_ff;
                  open_time_in  = time_ff;
               end
               if (ext_ff) begin
                  holding_in = 1'b0;
                  close_in   = price_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vol_mult_ff   <= VOL_MULT_RST;
         min_edge_ff   <= MIN_EDGE_RST;
         target_ff     <= TARGET_RST;
         stop_ff       <= STOP_RST;
         prev_ff       <= '0;
         holding_ff    <= 1'b0;
         open_price_ff <= '0;
         open_time_ff  <= '0;
         close_ff      <= '0;
         ent_ff        <= 1'b0;
         ext_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vol_mult_ff   <= vol_mult_in;
         min_edge_ff   <= min_edge_in;
         target_ff     <= target_in;
         stop_ff       <= stop_in;
         prev_ff       <= prev_in;
         holding_ff    <= holding_in;
         open_price_ff <= open_price_in;
         open_time_ff  <= open_time_in;
         close_ff      <= close_in;
         ent_ff        <= ent_in;
         ext_ff        <= ext_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      price_ff    <= price_in;
      time_ff     <= time_in;
      lat_ff      <= lat_in;
      p_ff        <= p_in;
   end

endmodule

### rtl/core/vbs_checker.sv
// ----------------------------------------------------------------------------
// vbs_checker: port-level checks for the volatility breakout signal
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module vbs_checker
   import vbs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data
);

   // one tick in flight: stall right after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input beat accepted while a tick is in flight");

   a_no_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.entry_flag && rsp_data.exit_flag))
      else $error("entry and exit on one beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

bind volatility_breakout_signal vbs_checker u_vbs_checker (.*);

### test/tb_volatility_breakout_signal.sv
// ----------------------------------------------------------------------------
// tb_volatility_breakout_signal: self-checking bench for the breakout detector
// Drives market-like tick streams with calm and burst regimes plus noise.
// A cycle-free model of the move windows and the entry/exit rules predicts
// each result beat. Register settings change between phases, from the
// extremes to random and fixed mid values. Sender gaps and receiver stalls vary by
// phase, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_volatility_breakout_signal;
   import vbs_pkg::*;

   localparam int          FAST_LEN       = SHORT_WINDOW_DEF;
   localparam int          SLOW_LEN       = LONG_WINDOW_DEF;
   localparam bit [63:0]   BPS_Q8         = 64'd2560000;
   localparam bit [63:0]   MAX_HOLD_MS    = 64'd4000;
   localparam bit [63:0]   MOVE_CAP       = 64'hFFFFFF;
   localparam int          HOLD_OFF_LEN   = 300;
   localparam int          QUIET_LIMIT    = 3000;
   localparam int          DRAIN_CYCLES   = 60;
   localparam int          REPORT_LIMIT   = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   volatility_breakout_signal dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // register copy
   bit [63:0] cfg_vol_mult = 64'(VOL_MULT_RST);
   bit [63:0] cfg_min_edge = 64'(MIN_EDGE_RST);
   bit [63:0] cfg_target   = 64'(TARGET_RST);
   bit [63:0] cfg_stop     = 64'(STOP_RST);

   // window and position state
   bit [23:0] fast_moves [FAST_LEN];
   bit [23:0] slow_moves [SLOW_LEN];
   int        fast_wr = 0;
   int        slow_wr = 0;
   int        fast_count = 0;
   int        slow_count = 0;
   bit [63:0] fast_sum = '0;
   bit [63:0] slow_sum = '0;
   bit [63:0] last_px = '0;
   bit        in_trade = 1'b0;
   bit [63:0] entry_px = '0;
   bit [63:0] entry_ms = '0;
   bit [63:0] exit_px = '0;

   req_type   tick_backlog [$];
   rsp_type   signal_backlog [$];

   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        hold_requests = 0;
   int        mismatches = 0;
   int        quiet_cycles = 0;

   // market walk
   bit [31:0] walk_px = 32'd1000000;
   bit [39:0] walk_ms = 40'd1000000;
   bit        in_burst = 1'b0;
   int        regime_left = 0;

   initial begin
      foreach (fast_moves[i]) fast_moves[i] = '0;
      foreach (slow_moves[i]) slow_moves[i] = '0;
   end

   function automatic rsp_type breakout_decision(input req_type t);
      bit [63:0] px, now, lat, diff, q;
      bit [23:0] mv;
      bit        go;
      rsp_type   r;
      px  = 64'(t.tick_price);
      now = 64'(t.tick_time_ms);
      lat = 64'(t.latency_ms);
      r.entry_flag = 1'b0;
      r.exit_flag  = 1'b0;
      if (last_px != 0) begin
         diff = (px >= last_px) ? px - last_px : last_px - px;
         q = diff * BPS_Q8 / last_px;
         mv = (q > MOVE_CAP) ? MOVE_CAP[23:0] : q[23:0];
         fast_sum = fast_sum - 64'(fast_moves[fast_wr]) + 64'(mv);
         fast_moves[fast_wr] = mv;
         fast_wr = (fast_wr + 1) % FAST_LEN;
         if (fast_count < FAST_LEN) fast_count++;
         slow_sum = slow_sum - 64'(slow_moves[slow_wr]) + 64'(mv);
         slow_moves[slow_wr] = mv;
         slow_wr = (slow_wr + 1) % SLOW_LEN;
         if (slow_count < SLOW_LEN) slow_count++;
      end
      last_px = px;
      if (!in_trade) begin
         go = (fast_count == FAST_LEN) && (slow_count == SLOW_LEN) && (slow_sum != 0);
         if (go)
            go = fast_sum * 64'(SLOW_LEN) * 64'd256 > slow_sum * 64'(FAST_LEN) * cfg_vol_mult;
         if (go)
            go = fast_sum * 64'd5 > (cfg_min_edge * 64'd5 + lat * 64'd4) * 64'(FAST_LEN);
         if (go) begin
            in_trade = 1'b1;
            entry_px = px;
            entry_ms = now;
            r.entry_flag = 1'b1;
         end
      end else begin
         if (entry_px == 0)
            go = (px != 0);
         else
            go = (px >= entry_px && (px - entry_px) * BPS_Q8 >= cfg_target * entry_px) ||
                 (px <= entry_px && (entry_px - px) * BPS_Q8 >= cfg_stop * entry_px);
         if (!go)
            go = (now >= entry_ms) && (now - entry_ms > MAX_HOLD_MS);
         if (go) begin
            in_trade = 1'b0;
            exit_px = px;
            r.exit_flag = 1'b1;
         end
      end
      r.opened_at_price = entry_px[31:0];
      r.closed_at_price = exit_px[31:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            signal_backlog.push_back(breakout_decision(req_data));
         if (!req_valid || !req_stall) begin
            if (tick_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= tick_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with an occasional long hold-off
   always @(posedge clock) begin : receiver
      int hold_left;
      int hold_served;
      if (reset) begin
         hold_left = 0;
         hold_served = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_OFF_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (signal_backlog.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result beat %h", rsp_data);
         end else begin
            want = signal_backlog.pop_front();
            if (rsp_data.entry_flag !== want.entry_flag)
               note_mismatch("entry_flag", 32'(want.entry_flag), 32'(rsp_data.entry_flag));
            if (rsp_data.exit_flag !== want.exit_flag)
               note_mismatch("exit_flag", 32'(want.exit_flag), 32'(rsp_data.exit_flag));
            if (rsp_data.opened_at_price !== want.opened_at_price)
               note_mismatch("opened_at_price", want.opened_at_price, rsp_data.opened_at_price);
            if (rsp_data.closed_at_price !== want.closed_at_price)
               note_mismatch("closed_at_price", want.closed_at_price, rsp_data.closed_at_price);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_tick(input logic [31:0] px, input logic [39:0] ms, input logic [23:0] lat);
      req_type t;
      t.tick_price   = px;
      t.tick_time_ms = ms;
      t.latency_ms   = lat;
      tick_backlog.push_back(t);
   endtask

   task automatic queue_market(input int n, input int noise_pct);
      req_type     t;
      int unsigned step, roll, back;
      repeat (n) begin
         if (regime_left == 0) begin
            in_burst = !in_burst;
            regime_left = in_burst ? $urandom_range(4, 18) : $urandom_range(15, 60);
         end
         regime_left--;
         roll = $urandom_range(99);
         if (roll < noise_pct) begin
            t = {$urandom(), $urandom(), $urandom()};
            if ($urandom_range(2) != 0) t.tick_price = walk_px;
         end else begin
            step = ($urandom_range(4) == 0) ? 0 :
                   in_burst ? $urandom_range(0, 6000) : $urandom_range(0, 60);
            if ($urandom_range(1) == 0) walk_px = walk_px + step;
            else if (walk_px > step + 1000) walk_px = walk_px - step;
            walk_ms = walk_ms + $urandom_range(0, 700);
            if (roll < noise_pct + 5) begin
               back = $urandom_range(0, 5000);
               if (walk_ms > back) walk_ms = walk_ms - back;
            end
            t.tick_price   = (roll == 99) ? 32'd0 : walk_px;
            t.tick_time_ms = walk_ms;
            t.latency_ms   = ($urandom_range(9) == 0) ? 24'($urandom()) :
                             24'($urandom_range(0, 1500));
         end
         tick_backlog.push_back(t);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_backlog.size() != 0 || req_valid || signal_backlog.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // called at a rising edge with the block idle
   task automatic program_regs(input logic [15:0] vm, input logic [23:0] edge_q8,
                               input logic [23:0] tgt, input logic [23:0] stp);
      logic [23:0] vals [4];
      csr_idx_type idx;
      vals[0] = 24'(vm);
      vals[1] = edge_q8;
      vals[2] = tgt;
      vals[3] = stp;
      for (int i = 0; i < 4; i++) begin
         idx = csr_idx_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         do @(posedge clock);
         while (!csr_ready);
         case (idx)
            CSR_VOL_MULT: cfg_vol_mult = 64'(vals[i][15:0]);
            CSR_MIN_EDGE: cfg_min_edge = 64'(vals[i]);
            CSR_TARGET:   cfg_target   = 64'(vals[i]);
            CSR_STOP:     cfg_stop     = 64'(vals[i]);
            default:      ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] vm, input logic [23:0] edge_q8,
                            input logic [23:0] tgt, input logic [23:0] stp,
                            input int idle_pct, input int stall_pct,
                            input int items, input int noise_pct, input bit squeeze);
      program_regs(vm, edge_q8, tgt, stp);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (squeeze) hold_requests++;
      queue_market(items, noise_pct);
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // field extremes, zero and saturated moves, equal prices
      queue_tick(32'd0,          40'd0,            24'd0);
      queue_tick(32'd1,          40'd1,            24'd0);
      queue_tick(32'hFFFFFFFF,   40'd2,            24'hFFFFFF);
      queue_tick(32'hFFFFFFFF,   40'hFFFFFFFFFF,   24'd0);
      queue_tick(32'd0,          40'd0,            24'hFFFFFF);
      queue_tick(32'd0,          40'd5,            24'd1);
      queue_tick(32'h80000000,   40'h8000000000,   24'h800000);
      queue_tick(32'h7FFFFFFF,   40'h7FFFFFFFFF,   24'h7FFFFF);
      queue_tick(32'd1,          40'h5555555555,   24'h555555);
      queue_tick(32'd2,          40'hAAAAAAAAAA,   24'hAAAAAA);
      queue_tick(32'd100,        40'd10,           24'd3);
      queue_tick(32'd100,        40'd9,            24'd3);
      queue_tick(32'd99,         40'd20,           24'd3);
      queue_tick(32'h55555555,   40'd30,           24'd0);
      queue_tick(32'hAAAAAAAA,   40'd40,           24'd0);
      queue_tick(32'd1000000,    40'd50,           24'd256);
      queue_tick(32'd1000001,    40'd60,           24'd256);
      queue_tick(32'd999999,     40'd70,           24'd256);
      queue_market(300, 3);
      wait_drained();

      run_phase(16'd0, 24'd0, 24'd0, 24'd0, 52, 0, 100, 8, 1'b0);
      run_phase(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 52, 80, 8, 1'b0);
      run_phase(16'($urandom_range(128, 1024)), 24'($urandom_range(0, 4000)),
                24'($urandom_range(0, 8000)), 24'($urandom_range(0, 8000)),
                27, 27, 120, 3, 1'b1);
      run_phase(16'd256, 24'd512, 24'd5000, 24'd3000, 0, 0, 150, 3, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && signal_backlog.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### filelist.f
rtl/core/vbs_pkg.sv
rtl/core/vbs_mul.sv
rtl/core/vbs_div.sv
rtl/core/vbs_ring.sv
rtl/core/volatility_breakout_signal.sv
rtl/core/vbs_checker.sv
test/tb_volatility_breakout_signal.sv
